FILE: rtl/kufe_pkg.sv
// kufe_pkg: shared types, codes and constants for the union-find engine
// depends on nothing; imported by every module of the engine
`timescale 1ns / 1ps
`default_nettype none

package kufe_pkg;

  localparam int unsigned MAX_VERTICES_DEFAULT = 1024;

  localparam int unsigned VERTEX_W = 10;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned TOTAL_W  = 48;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned RANK_W   = 4;

  localparam logic [COUNT_W-1:0] VCOUNT_RESET = 11'd1024;
  localparam logic [RANK_W-1:0]  RANK_MAX     = 4'd15;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX    = {TOTAL_W{1'b1}};

  typedef enum logic [0:0] {
    KIND_CLEAR = 1'b0,
    KIND_EDGE  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    logic [VERTEX_W-1:0]  first_vertex;
    logic [VERTEX_W-1:0]  second_vertex;
    logic [WEIGHT_W-1:0]  edge_weight;
  } req_t;

  typedef struct packed {
    logic                joined;
    logic [TOTAL_W-1:0]  tree_weight;
    logic                bad_vertex;
  } res_t;

  // datapath operations issued by the controller, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_FIND_INIT,
    OP_FIND_STEP,
    OP_COMP_INIT,
    OP_COMP_STEP,
    OP_RANK_A,
    OP_RANK_B,
    OP_LINK
  } op_t;

  typedef struct packed {
    op_t  op;
    logic side;    // 0 first endpoint, 1 second endpoint
    logic report;  // present a result in the next cycle
  } cmd_t;

  typedef struct packed {
    logic in_clear;      // request on the input is a clear
    logic in_bad;        // an endpoint on the input is out of range
    logic n_zero;        // no vertices in use
    logic clear_last;    // sweep is at the last vertex
    logic hop_root;      // walked node is its own parent
    logic comp_at_root;  // endpoint is already its root
    logic comp_end;      // next node on the path is the root
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/kufe_ctrl.sv
// kufe_ctrl: sequencing state machine for clear sweeps and edge processing
// depends on kufe_pkg; drives kufe_datapath through cmd_t, reads status_t
`timescale 1ns / 1ps
`default_nettype none

module kufe_ctrl
  import kufe_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire status_t status,
  output cmd_t         cmd,
  output logic         busy
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_FIND_INIT,
    S_FIND,
    S_COMP_INIT,
    S_COMP,
    S_RANK_A,
    S_RANK_B,
    S_LINK
  } state_t;

  state_t state, state_next;
  logic   side, side_next;
  state_t after_comp;

  always_comb begin
    after_comp = side ? S_RANK_A : S_FIND_INIT;
  end

  always_comb begin
    state_next = state;
    side_next  = side;
    cmd.op     = OP_NONE;
    cmd.side   = side;
    cmd.report = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LOAD;
          side_next = 1'b0;
          if (status.in_clear) begin
            if (status.n_zero) begin
              cmd.report = 1'b1;
            end else begin
              state_next = S_CLEAR;
            end
          end else if (status.in_bad) begin
            cmd.report = 1'b1;
          end else begin
            state_next = S_FIND_INIT;
          end
        end
      end
      S_CLEAR: begin
        cmd.op = OP_CLEAR;
        if (status.clear_last) begin
          cmd.report = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FIND_INIT: begin
        cmd.op     = OP_FIND_INIT;
        state_next = S_FIND;
      end
      S_FIND: begin
        cmd.op = OP_FIND_STEP;
        if (status.hop_root) begin
          state_next = S_COMP_INIT;
        end
      end
      S_COMP_INIT: begin
        cmd.op = OP_COMP_INIT;
        if (status.comp_at_root) begin
          state_next = after_comp;
          side_next  = 1'b1;
        end else begin
          state_next = S_COMP;
        end
      end
      S_COMP: begin
        cmd.op = OP_COMP_STEP;
        if (status.comp_end) begin
          state_next = after_comp;
          side_next  = 1'b1;
        end
      end
      S_RANK_A: begin
        cmd.op     = OP_RANK_A;
        state_next = S_RANK_B;
      end
      S_RANK_B: begin
        cmd.op     = OP_RANK_B;
        state_next = S_LINK;
      end
      S_LINK: begin
        cmd.op     = OP_LINK;
        cmd.report = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      side  <= 1'b0;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      side  <= side_next;
      busy  <= (state_next != S_IDLE);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/kufe_datapath.sv
// kufe_datapath: parent and rank memories, walk registers, running total
// depends on kufe_pkg; commanded by kufe_ctrl
`timescale 1ns / 1ps
`default_nettype none

module kufe_datapath
  import kufe_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire req_t                req,
  input  wire logic                cfg_wr_en,
  input  wire logic [COUNT_W-1:0]  cfg_wr_data,
  input  wire cmd_t                cmd,
  output status_t                  status,
  output logic                     result_valid,
  output res_t                     result
);

  localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned XW = (CW > COUNT_W) ? CW : COUNT_W;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_VERTICES);

  logic [COUNT_W-1:0]  vertex_count;
  logic [AW-1:0]       va, vb, cur, root_a, root_b;
  logic [WEIGHT_W-1:0] weight;
  logic                bad, joined;
  logic [RANK_W-1:0]   rank_a;
  logic [TOTAL_W-1:0]  total;
  logic [CW-1:0]       idx;

  logic [AW-1:0]       parent_mem [MAX_VERTICES];
  logic [RANK_W-1:0]   rank_mem   [MAX_VERTICES];
  logic [AW-1:0]       p_rd_q;
  logic [RANK_W-1:0]   r_rd_q;

  logic [XW-1:0]       vc_x, n_x;
  logic [CW-1:0]       n;
  logic [AW-1:0]       vertex_sel, root_sel;
  logic                roots_differ;
  logic [TOTAL_W:0]    sum;

  logic                p_rd_en, p_wr_en, r_rd_en, r_wr_en;
  logic [AW-1:0]       p_rd_addr, p_wr_addr, p_wr_data, r_rd_addr, r_wr_addr;
  logic [RANK_W-1:0]   r_wr_data;

  // effective vertex count, capped at the table depth
  always_comb begin
    vc_x = XW'(vertex_count);
    n_x  = (vc_x > MAX_X) ? MAX_X : vc_x;
    n    = CW'(n_x);
  end

  assign vertex_sel   = cmd.side ? vb : va;
  assign root_sel     = cmd.side ? root_b : root_a;
  assign roots_differ = (root_a != root_b);
  assign sum          = {1'b0, total} + (TOTAL_W + 1)'(weight);

  always_comb begin
    status.in_clear     = (req.kind == KIND_CLEAR);
    status.in_bad       = (XW'(req.first_vertex) >= n_x) || (XW'(req.second_vertex) >= n_x);
    status.n_zero       = (n == '0);
    status.clear_last   = (CW'(idx + 1'b1) == n);
    status.hop_root     = (p_rd_q == cur);
    status.comp_at_root = (vertex_sel == root_sel);
    status.comp_end     = (p_rd_q == root_sel);
  end

  // memory port steering
  always_comb begin
    p_rd_en   = 1'b0;
    p_rd_addr = vertex_sel;
    p_wr_en   = 1'b0;
    p_wr_addr = idx[AW-1:0];
    p_wr_data = idx[AW-1:0];
    r_rd_en   = 1'b0;
    r_rd_addr = root_a;
    r_wr_en   = 1'b0;
    r_wr_addr = idx[AW-1:0];
    r_wr_data = '0;
    case (cmd.op)
      OP_CLEAR: begin
        p_wr_en = 1'b1;
        r_wr_en = 1'b1;
      end
      OP_FIND_INIT: begin
        p_rd_en = 1'b1;
      end
      OP_FIND_STEP: begin
        p_rd_en   = !status.hop_root;
        p_rd_addr = p_rd_q;
      end
      OP_COMP_INIT: begin
        p_rd_en = !status.comp_at_root;
      end
      OP_COMP_STEP: begin
        p_rd_en   = !status.comp_end;
        p_rd_addr = p_rd_q;
        p_wr_en   = 1'b1;
        p_wr_addr = cur;
        p_wr_data = root_sel;
      end
      OP_RANK_A: begin
        r_rd_en = 1'b1;
      end
      OP_RANK_B: begin
        r_rd_en   = 1'b1;
        r_rd_addr = root_b;
      end
      OP_LINK: begin
        p_wr_en = roots_differ;
        if (rank_a > r_rd_q) begin
          p_wr_addr = root_b;
          p_wr_data = root_a;
        end else begin
          p_wr_addr = root_a;
          p_wr_data = root_b;
          r_wr_en   = roots_differ && (rank_a == r_rd_q) && (r_rd_q < RANK_MAX);
          r_wr_addr = root_b;
          r_wr_data = r_rd_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (p_rd_en) begin
      p_rd_q <= parent_mem[p_rd_addr];
    end
    if (p_wr_en) begin
      parent_mem[p_wr_addr] <= p_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (r_rd_en) begin
      r_rd_q <= rank_mem[r_rd_addr];
    end
    if (r_wr_en) begin
      rank_mem[r_wr_addr] <= r_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VCOUNT_RESET;
      total        <= '0;
      joined       <= 1'b0;
      bad          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.report;
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end
      case (cmd.op)
        OP_LOAD: begin
          joined <= 1'b0;
          bad    <= (req.kind == KIND_EDGE) && status.in_bad;
          if (req.kind == KIND_CLEAR) begin
            total <= '0;
          end
        end
        OP_LINK: begin
          joined <= roots_differ;
          if (roots_differ) begin
            total <= sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // walk registers, no reset needed
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        va     <= AW'(req.first_vertex);
        vb     <= AW'(req.second_vertex);
        weight <= req.edge_weight;
        idx    <= '0;
      end
      OP_CLEAR: begin
        idx <= CW'(idx + 1'b1);
      end
      OP_FIND_INIT, OP_COMP_INIT: begin
        cur <= vertex_sel;
      end
      OP_FIND_STEP: begin
        if (status.hop_root) begin
          if (cmd.side) begin
            root_b <= cur;
          end else begin
            root_a <= cur;
          end
        end else begin
          cur <= p_rd_q;
        end
      end
      OP_COMP_STEP: begin
        cur <= p_rd_q;
      end
      OP_RANK_B: begin
        rank_a <= r_rd_q;
      end
      default: begin
      end
    endcase
  end

  assign result.joined      = joined;
  assign result.tree_weight = total;
  assign result.bad_vertex  = bad;

endmodule

`default_nettype wire

FILE: rtl/kruskal_union_find_engine.sv
// kruskal_union_find_engine: disjoint-set engine for minimum spanning trees
// depends on kufe_pkg, kufe_ctrl and kufe_datapath
// sequencing: a clear sweeps the n vertices in use (no sweep if none); a bad
//   edge is answered from idle; a good edge walks and compresses both paths,
//   paced by the single read port of the parent memory (one hop a cycle)
// throughput: one request at a time, the next taken the cycle the result shows
// reset: synchronous, clears control and total, sets vertex count (1024); tables
//   hold nothing until the first clear request; results cannot be stalled
`timescale 1ns / 1ps
`default_nettype none

module kruskal_union_find_engine
  import kufe_pkg::*;
#(
  parameter int unsigned MAX_VERTICES = MAX_VERTICES_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // request side: taken when start is high and busy is low
  input  wire logic                start,
  input  wire req_t                req,
  output logic                     busy,
  // vertex count register, to be written only while idle (not enforced here)
  input  wire logic                cfg_wr_en,
  input  wire logic [COUNT_W-1:0]  cfg_wr_data,
  // result side: one-cycle strobe, no back-pressure
  output logic                     result_valid,
  output res_t                     result
);

  cmd_t    cmd;     // per-cycle operation for the datapath
  status_t status;  // compares and flags back to the controller

  // controller walks: idle, clear sweep, find a, compress a,
  // find b, compress b, two rank reads, link and report
  kufe_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // datapath holds both tables, the walk pointer and the saturating total
  kufe_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

FILE: sim/tb_kruskal_union_find_engine.sv
// tb_kruskal_union_find_engine: self-checking bench for the union-find engine
// depends on kufe_pkg and kruskal_union_find_engine; every result is predicted
// by a disjoint-set forest kept here and compared field by field
`timescale 1ns / 1ps

module tb_kruskal_union_find_engine;
  import kufe_pkg::*;

  localparam int unsigned VERTS       = MAX_VERTICES_DEFAULT;
  localparam int unsigned STALL_LIMIT = 6000;  // outlasts a full 1024-vertex clear sweep
  localparam int unsigned RANDOM_REQS = 700;

  // engine ports; all inputs driven to known values from time zero
  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               start        = 1'b0;
  req_t               req          = '0;
  logic               busy;
  logic               cfg_wr_en    = 1'b0;
  logic [COUNT_W-1:0] cfg_wr_data  = '0;
  logic               result_valid;
  res_t               result;

  // forest mirrored in the bench: parents, ranks, running total, vertex count
  logic [VERTEX_W-1:0] parent_of [VERTS];
  logic [RANK_W-1:0]   rank_of   [VERTS];
  logic [TOTAL_W-1:0]  mst_total = '0;
  logic [COUNT_W-1:0]  vcount    = VCOUNT_RESET;

  // requests waiting to be issued, and the results owed by accepted requests
  req_t req_backlog [$];
  res_t owed_res    [$];

  int unsigned burst_left   = 0;
  int unsigned gap_left     = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count   = 0;
  int unsigned n_clears     = 0;
  int unsigned n_joins      = 0;
  int unsigned n_dropped    = 0;
  int unsigned n_bad        = 0;
  int unsigned n_checked    = 0;
  int unsigned n_settings   = 0;
  int unsigned random_reqs  = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  kruskal_union_find_engine #(
    .MAX_VERTICES(VERTS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req          (req),
    .busy         (busy),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .result_valid (result_valid),
    .result       (result)
  );

  // ---------------------------------------------------------------------------
  // forest model
  // ---------------------------------------------------------------------------

  // walk to the root, then point every node on the path straight at it
  function automatic logic [VERTEX_W-1:0] root_of(logic [VERTEX_W-1:0] v);
    logic [VERTEX_W-1:0] top;
    logic [VERTEX_W-1:0] nxt;
    int unsigned         hops;
    top  = v;
    hops = 0;
    while (parent_of[top] != top && hops < VERTS) begin
      top = parent_of[top];
      hops++;
    end
    hops = 0;
    while (v != top && hops < VERTS) begin
      nxt          = parent_of[v];
      parent_of[v] = top;
      v            = nxt;
      hops++;
    end
    return top;
  endfunction

  // apply one request to the forest and return the result it must produce
  function automatic res_t forest_step(req_t r);
    res_t                ans;
    int unsigned         eff;
    int unsigned         i;
    logic [VERTEX_W-1:0] ra;
    logic [VERTEX_W-1:0] rb;
    logic [TOTAL_W:0]    sum;
    ans = '0;
    // counts above the table size behave as the table size
    eff = (vcount > VERTS) ? VERTS : vcount;
    if (r.kind == KIND_CLEAR) begin
      for (i = 0; i < eff; i++) begin
        parent_of[i] = VERTEX_W'(i);
        rank_of[i]   = '0;
      end
      mst_total = '0;
      n_clears++;
    end else if (r.first_vertex >= eff || r.second_vertex >= eff) begin
      // out-of-range endpoint: flagged, forest and total untouched
      ans.bad_vertex = 1'b1;
      n_bad++;
    end else begin
      ra = root_of(r.first_vertex);
      rb = root_of(r.second_vertex);
      if (ra == rb) begin
        n_dropped++;
      end else begin
        ans.joined = 1'b1;
        n_joins++;
        sum       = {1'b0, mst_total} + r.edge_weight;
        mst_total = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
        // union by rank; a tie hangs the first root under the second
        if (rank_of[ra] > rank_of[rb]) begin
          parent_of[rb] = ra;
        end else begin
          parent_of[ra] = rb;
          if (rank_of[ra] == rank_of[rb] && rank_of[rb] != RANK_MAX)
            rank_of[rb] = rank_of[rb] + 1'b1;
        end
      end
    end
    ans.tree_weight = mst_total;
    return ans;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver: bursts of random length separated by random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    logic taken;
    res_t due;
    taken = start && !busy;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      // engine still working: keep the request on the port unchanged
    end else begin
      if (taken) begin
        due = forest_step(req);
        owed_res.insert(owed_res.size(), due);
        void'(req_backlog.pop_front());
      end
      if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (req_backlog.size() != 0) begin
        start <= 1'b1;
        req   <= req_backlog[0];
        if (burst_left == 0) begin
          // mostly short bursts, now and then a long run with no idling
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                   : $urandom_range(1, 10);
        end
        burst_left--;
        if (burst_left == 0)
          gap_left = $urandom_range(1, 12);
      end else begin
        start <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: every strobe is matched against the oldest owed result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    res_t want;
    if (!rst && result_valid) begin
      n_checked++;
      if (owed_res.size() == 0) begin
        $error("result strobe with no request outstanding");
        fail_count++;
      end else begin
        want = owed_res.pop_front();
        if (result.joined !== want.joined) begin
          $error("joined: expected %0b, got %0b", want.joined, result.joined);
          fail_count++;
        end
        if (result.tree_weight !== want.tree_weight) begin
          $error("tree_weight: expected %0h, got %0h", want.tree_weight,
                 result.tree_weight);
          fail_count++;
        end
        if (result.bad_vertex !== want.bad_vertex) begin
          $error("bad_vertex: expected %0b, got %0b", want.bad_vertex,
                 result.bad_vertex);
          fail_count++;
        end
      end
    end
  end

  // watchdog: ends the run if neither side moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == STALL_LIMIT) begin
      $error("no request or result for %0d cycles", STALL_LIMIT);
      $display("kruskal_union_find_engine test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_req(input kind_t k, input int unsigned a, b,
                         input logic [WEIGHT_W-1:0] w);
    req_t r;
    r.kind          = k;
    r.first_vertex  = VERTEX_W'(a);
    r.second_vertex = VERTEX_W'(b);
    r.edge_weight   = w;
    req_backlog.insert(req_backlog.size(), r);
  endtask

  // block until every request is issued and every result is back
  task automatic wait_idle();
    while (req_backlog.size() != 0 || start || owed_res.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // register write while the engine is idle; the bench copy follows it
  task automatic set_vertex_count(input int unsigned v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= COUNT_W'(v);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    vcount = COUNT_W'(v);
    n_settings++;
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned         eff;
    int unsigned         edges;
    int unsigned         pick;
    int unsigned         a;
    int unsigned         b;
    logic [WEIGHT_W:0]   w;
    logic [WEIGHT_W-1:0] step_max;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at the reset count of 1024; the first clear sweeps the
    // whole table, so no later edge can touch an unwritten entry
    add_req(KIND_CLEAR, 1023, 1023, '1);      // endpoint and weight fields ignored
    add_req(KIND_EDGE,  0, 1023, '1);         // extreme endpoints, largest weight
    add_req(KIND_EDGE,  1023, 0, '1);         // same tree, dropped
    add_req(KIND_EDGE,  5, 5, '0);            // self loop
    add_req(KIND_EDGE,  1, 2, '0);            // equal ranks, first under second
    add_req(KIND_EDGE,  3, 4, 32'd1);
    add_req(KIND_EDGE,  2, 4, 32'd2);         // equal ranks one level up
    add_req(KIND_EDGE,  0, 1, 32'd3);         // first root lower rank, compresses 1
    add_req(KIND_EDGE,  4, 6, 32'd4);         // first root higher rank
    add_req(KIND_EDGE,  0, 3, 32'd5);         // two-hop path, compressed
    add_req(KIND_EDGE,  1023, 6, 32'd5);

    // zero count: every endpoint bad, clear zeroes the total and nothing else
    wait_idle();
    set_vertex_count(0);
    add_req(KIND_EDGE,  0, 0, 32'd7);
    add_req(KIND_CLEAR, 0, 0, '0);
    add_req(KIND_EDGE,  1023, 1023, 32'd7);

    // count above the table size saturates; forest survived the empty clear
    wait_idle();
    set_vertex_count(2047);
    add_req(KIND_EDGE,  0, 6, 32'd8);
    add_req(KIND_EDGE,  7, 1023, 32'h8000_0000);

    // single vertex, then two
    wait_idle();
    set_vertex_count(1);
    add_req(KIND_EDGE,  0, 1, 32'd9);
    add_req(KIND_EDGE,  0, 0, 32'd9);
    add_req(KIND_CLEAR, 1, 1, '0);
    add_req(KIND_EDGE,  0, 0, 32'd9);

    wait_idle();
    set_vertex_count(2);
    add_req(KIND_CLEAR, 0, 0, '0);
    add_req(KIND_EDGE,  0, 1, '1);
    add_req(KIND_EDGE,  1, 0, '1);
    add_req(KIND_EDGE,  2, 1, '1);

    // random part: each phase picks a count, mostly clears and feeds edges in
    // ascending weight order, with stray clears, bad endpoints and unsorted
    // weights mixed in; small counts dominate so trees merge deeply
    while (random_reqs < RANDOM_REQS) begin
      wait_idle();
      pick = $urandom_range(0, 19);
      if (pick == 0)
        set_vertex_count(0);
      else if (pick == 1)
        set_vertex_count(1);
      else if (pick == 2)
        set_vertex_count(VERTS);
      else if (pick == 3)
        set_vertex_count($urandom_range(VERTS + 1, 2047));
      else if (pick <= 5)
        set_vertex_count($urandom_range(65, 400));
      else
        set_vertex_count($urandom_range(2, 64));

      eff      = (vcount > VERTS) ? VERTS : vcount;
      edges    = (eff < 2) ? 8 : ((3 * eff > 60) ? 60 : 3 * eff);
      w        = $urandom() >> $urandom_range(0, 31);
      step_max = $urandom_range(0, 1) ? 32'd255 : 32'h00FF_FFFF;

      // now and then carry the forest over from the previous phase
      if ($urandom_range(0, 4) != 0) begin
        add_req(KIND_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023),
                $urandom());
        random_reqs++;
      end

      repeat (edges) begin
        pick = $urandom_range(0, 19);
        w    = w + $urandom_range(0, step_max);
        if (w[WEIGHT_W])
          w = {1'b0, {WEIGHT_W{1'b1}}};
        if (eff == 0) begin
          a = $urandom_range(0, VERTS - 1);
          b = $urandom_range(0, VERTS - 1);
        end else begin
          a = $urandom_range(0, eff - 1);
          b = $urandom_range(0, eff - 1);
        end
        if (pick == 0) begin
          add_req(KIND_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom());
        end else begin
          // out-of-range endpoint on one side or both
          if (pick <= 2 && eff < VERTS) begin
            if (pick == 1 || $urandom_range(0, 1))
              a = $urandom_range(eff, VERTS - 1);
            if (pick == 2)
              b = $urandom_range(eff, VERTS - 1);
          end
          add_req(KIND_EDGE, a, b, (pick == 3) ? $urandom() : w[WEIGHT_W-1:0]);
        end
        random_reqs++;
      end
    end

    // drain, then give the engine time to show any stray strobe
    wait_idle();
    repeat (20) @(posedge clk);

    $display("covered %0d clears, %0d joins, %0d same-tree edges, %0d bad edges",
             n_clears, n_joins, n_dropped, n_bad);
    $display("%0d results checked over %0d vertex count settings",
             n_checked, n_settings);
    if (fail_count == 0 && owed_res.size() == 0) begin
      $display("kruskal_union_find_engine test passed");
    end else begin
      $display("kruskal_union_find_engine test failed");
    end
    $finish;
  end

endmodule
